// File: sv/rmis_pkg.sv
// package: request and result types, opcode constants and helpers for the instruction step
`timescale 1ns / 1ps
package rmis_pkg;

  localparam int REG_COUNT_DEF     = 32;
  localparam int PROGRAM_DEPTH_DEF = 64;

  localparam int WORD_W   = 32;
  localparam int REG_IDX_W = 5;
  localparam int LINE_W   = 6;
  localparam int OP_W     = 4;

  localparam logic [REG_IDX_W-1:0] FLAG_ENTRY = 5'd16;
  localparam logic [REG_IDX_W-1:0] SIGN_ENTRY = 5'd19;

  // opcode prefixes
  localparam logic [16:0] P17_ADD  = 17'd0;
  localparam logic [16:0] P17_MUL  = 17'd1;
  localparam logic [16:0] P17_SUB  = 17'd2;
  localparam logic [18:0] P19_MOV  = 19'd12;
  localparam logic [18:0] P19_CMP  = 19'd13;
  localparam logic [21:0] P22_CMPI = 22'd112;
  localparam logic [24:0] P25_OUT  = 25'd904;
  localparam logic [24:0] P25_IN   = 25'd905;
  localparam logic [26:0] P27_INC  = 27'd3624;
  localparam logic [26:0] P27_JUMP = 27'd3625;
  localparam logic [26:0] P27_JE   = 27'd3626;
  localparam logic [26:0] P27_JGT  = 27'd3627;
  localparam logic [31:0] HLT_WORD = 32'd116096;

  typedef enum logic [OP_W-1:0] {
    OP_NONE    = 4'd0,
    OP_ADD     = 4'd1,
    OP_MUL     = 4'd2,
    OP_SUB     = 4'd3,
    OP_MOV     = 4'd4,
    OP_CMP     = 4'd5,
    OP_CMPI    = 4'd6,
    OP_OUT     = 4'd7,
    OP_IN      = 4'd8,
    OP_INC     = 4'd9,
    OP_JUMP    = 4'd10,
    OP_JE      = 4'd11,
    OP_JGT     = 4'd12,
    OP_HLT     = 4'd13,
    OP_IGNORED = 4'd14
  } op_e;

  typedef struct packed {
    logic [WORD_W-1:0] instruction;
    logic [WORD_W-1:0] in_value;
  } instr_req_t;

  typedef struct packed {
    logic [LINE_W-1:0] next_line;
    logic              out_valid;
    logic [WORD_W-1:0] out_value;
    logic              halted;
    logic [OP_W-1:0]   operation;
  } step_res_t;

  // three-way unsigned compare: 1 greater, all-ones less, 0 equal
  function automatic logic [WORD_W-1:0] cmp3(input logic [WORD_W-1:0] a,
                                             input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] res;
    if (a > b) begin
      res = 32'd1;
    end else if (a < b) begin
      res = '1;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  // first source register index: reg field of MOV/CMP, OUT/IN, else src1
  function automatic logic [REG_IDX_W-1:0] src_a_idx(input logic [WORD_W-1:0] ins);
    logic [REG_IDX_W-1:0] idx;
    if (ins[31:13] == P19_MOV || ins[31:13] == P19_CMP) begin
      idx = ins[12:8];
    end else if (ins[31:7] == P25_OUT || ins[31:7] == P25_IN) begin
      idx = ins[6:2];
    end else begin
      idx = ins[9:5];
    end
    return idx;
  endfunction

endpackage

// File: sv/register_machine_instruction_step.sv
// top level: register machine instruction step with register file and result register
// pipeline: input stage, then result register; throughput one request per cycle
// while the output is not stalled; register file read at accept, written as the result
// is registered, with a bypass from that write to the read taken at the same edge
// reset: clears register file valid bits (entries read as zero), flag, sign, line, halt mark
// and both pipeline valids; payload and memory contents are not reset
`timescale 1ns / 1ps
module register_machine_instruction_step
  import rmis_pkg::*;
#(
  parameter int REG_COUNT     = REG_COUNT_DEF,
  parameter int PROGRAM_DEPTH = PROGRAM_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  instr_req_t in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output step_res_t  out_res_o
);

  localparam int RegIdxW = $clog2(REG_COUNT);
  localparam int LineW   = $clog2(PROGRAM_DEPTH);

  // register file storage, entries 16 and 19 live in flag_q and sign_q
  logic [WORD_W-1:0]    mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] valid_q;
  logic [WORD_W-1:0]    flag_q, flag_d;
  logic [WORD_W-1:0]    sign_q, sign_d;
  logic [LineW-1:0]     line_q, line_d;
  logic                 halt_q, halt_d;

  // input stage
  logic                 s1_valid_q;
  logic [WORD_W-1:0]    ins_q;
  logic [WORD_W-1:0]    inv_q;
  logic [REG_IDX_W-1:0] idx_a_q;
  logic [WORD_W-1:0]    rdata_a_q, rdata_b_q;
  logic                 rvalid_a_q, rvalid_b_q;
  logic                 byp_a_q, byp_b_q;
  logic [WORD_W-1:0]    byp_data_q;

  // result register
  logic      out_valid_q;
  step_res_t out_q, out_d;

  logic in_accept, s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  // read addresses of the incoming request
  logic [REG_IDX_W-1:0] raddr_a, raddr_b;
  logic                 rin_a, rin_b;
  assign raddr_a = src_a_idx(in_req_i.instruction);
  assign raddr_b = in_req_i.instruction[4:0];
  assign rin_a   = 32'(raddr_a) < REG_COUNT;
  assign rin_b   = 32'(raddr_b) < REG_COUNT;

  // stage 1 decode
  logic [REG_IDX_W-1:0] f0, f2, f8, f10;
  logic [7:0]           imm;
  assign f0  = ins_q[4:0];
  assign f2  = ins_q[6:2];
  assign f8  = ins_q[12:8];
  assign f10 = ins_q[14:10];
  assign imm = ins_q[7:0];

  logic [WORD_W-1:0] mem_a, mem_b, val_a, val_b;
  always_comb begin
    mem_a = byp_a_q ? byp_data_q : (rvalid_a_q ? rdata_a_q : '0);
    mem_b = byp_b_q ? byp_data_q : (rvalid_b_q ? rdata_b_q : '0);
    if (32'(idx_a_q) >= REG_COUNT) begin
      val_a = '0;
    end else if (idx_a_q == FLAG_ENTRY) begin
      val_a = flag_q;
    end else if (idx_a_q == SIGN_ENTRY) begin
      val_a = sign_q;
    end else begin
      val_a = mem_a;
    end
    if (32'(f0) >= REG_COUNT) begin
      val_b = '0;
    end else if (f0 == FLAG_ENTRY) begin
      val_b = flag_q;
    end else if (f0 == SIGN_ENTRY) begin
      val_b = sign_q;
    end else begin
      val_b = mem_b;
    end
  end

  logic [WORD_W-1:0] sum_ab, prod_ab, diff_ab, inc_b;
  assign sum_ab  = val_a + val_b;
  assign prod_ab = val_a * val_b;
  assign diff_ab = val_a - val_b;
  assign inc_b   = val_b + 32'd1;

  // execute
  op_e                  op;
  logic                 we;
  logic [REG_IDX_W-1:0] widx;
  logic [WORD_W-1:0]    wdata;
  logic                 sign_we, flag_we, sign_bit;
  logic [WORD_W-1:0]    flag_val;
  logic [LineW-1:0]     line_inc, next_line;
  logic                 ov;
  logic [WORD_W-1:0]    oval;

  assign line_inc = (line_q == LineW'(PROGRAM_DEPTH - 1)) ? '0 : line_q + 1'b1;

  always_comb begin
    op        = OP_NONE;
    we        = 1'b0;
    widx      = f10;
    wdata     = sum_ab;
    sign_we   = 1'b0;
    sign_bit  = 1'b0;
    flag_we   = 1'b0;
    flag_val  = '0;
    next_line = line_inc;
    ov        = 1'b0;
    oval      = '0;
    halt_d    = halt_q;
    if (halt_q) begin
      op        = OP_IGNORED;
      next_line = line_q;
    end else if (ins_q[31:15] == P17_ADD) begin
      op = OP_ADD; we = 1'b1; wdata = sum_ab; sign_we = 1'b1; sign_bit = sum_ab[31];
    end else if (ins_q[31:15] == P17_MUL) begin
      op = OP_MUL; we = 1'b1; wdata = prod_ab; sign_we = 1'b1; sign_bit = prod_ab[31];
    end else if (ins_q[31:15] == P17_SUB) begin
      op = OP_SUB; we = 1'b1; wdata = diff_ab; sign_we = 1'b1; sign_bit = val_a < val_b;
    end else if (ins_q[31:13] == P19_MOV) begin
      op = OP_MOV; we = 1'b1; widx = f8; wdata = {24'd0, imm};
    end else if (ins_q[31:13] == P19_CMP) begin
      op = OP_CMP; flag_we = 1'b1; flag_val = cmp3(val_a, {24'd0, imm});
    end else if (ins_q[31:10] == P22_CMPI) begin
      op = OP_CMPI; flag_we = 1'b1; flag_val = cmp3(val_a, val_b);
    end else if (ins_q[31:7] == P25_OUT) begin
      op = OP_OUT; ov = 1'b1; oval = val_a;
    end else if (ins_q[31:7] == P25_IN) begin
      op = OP_IN; we = 1'b1; widx = f2; wdata = inv_q;
    end else if (ins_q[31:5] == P27_INC) begin
      op = OP_INC; we = 1'b1; widx = f0; wdata = inc_b; sign_we = 1'b1; sign_bit = inc_b[31];
    end else if (ins_q[31:5] == P27_JUMP) begin
      op = OP_JUMP; next_line = LineW'(f0);
    end else if (ins_q[31:5] == P27_JE) begin
      op = OP_JE;
      if (flag_q == '0) begin
        next_line = LineW'(f0);
      end
    end else if (ins_q[31:5] == P27_JGT) begin
      op = OP_JGT;
      if (flag_q == '0 || flag_q == 32'd1) begin
        next_line = LineW'(f0);
      end
    end else if (ins_q == HLT_WORD) begin
      op = OP_HLT; halt_d = 1'b1; next_line = line_q;
    end
  end

  // state writes, the sign write wins over the destination
  logic w_in, mem_we;
  assign w_in   = we && (32'(widx) < REG_COUNT);
  assign mem_we = s1_adv && w_in && widx != FLAG_ENTRY && widx != SIGN_ENTRY;

  always_comb begin
    flag_d = flag_q;
    sign_d = sign_q;
    line_d = line_q;
    if (s1_adv) begin
      line_d = next_line;
      if (w_in && widx == FLAG_ENTRY) begin
        flag_d = wdata;
      end
      if (w_in && widx == SIGN_ENTRY) begin
        sign_d = wdata;
      end
      if (flag_we) begin
        flag_d = flag_val;
      end
      if (sign_we) begin
        sign_d = {31'd0, sign_bit};
      end
    end
  end

  always_comb begin
    out_d.next_line = LINE_W'(next_line);
    out_d.out_valid = ov;
    out_d.out_value = oval;
    out_d.halted    = halt_d;
    out_d.operation = op;
  end

  // memory: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[widx[RegIdxW-1:0]] <= wdata;
    end
    if (in_accept && rin_a) begin
      rdata_a_q <= mem_q[raddr_a[RegIdxW-1:0]];
    end
    if (in_accept && rin_b) begin
      rdata_b_q <= mem_q[raddr_b[RegIdxW-1:0]];
    end
  end

  // input stage payload and bypass, and the result register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ins_q      <= in_req_i.instruction;
      inv_q      <= in_req_i.in_value;
      idx_a_q    <= raddr_a;
      byp_a_q    <= mem_we && widx == raddr_a;
      byp_b_q    <= mem_we && widx == raddr_b;
      byp_data_q <= wdata;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rvalid_a_q  <= 1'b0;
      rvalid_b_q  <= 1'b0;
      flag_q      <= '0;
      sign_q      <= '0;
      line_q      <= '0;
      halt_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[widx[RegIdxW-1:0]] <= 1'b1;
      end
      if (in_accept) begin
        rvalid_a_q <= rin_a && valid_q[raddr_a[RegIdxW-1:0]];
        rvalid_b_q <= rin_b && valid_q[raddr_b[RegIdxW-1:0]];
      end
      flag_q <= flag_d;
      sign_q <= sign_d;
      line_q <= line_d;
      if (s1_adv) begin
        halt_q <= halt_d;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // assertions
  a_adv_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("result register not loaded after stage advance");

  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt mark cleared");

  a_halt_ignores : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && halt_q) |=> (out_q.operation == OP_IGNORED && $stable(line_q)))
    else $error("request after halt changed state");

  a_line_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(line_q) < PROGRAM_DEPTH)
    else $error("line counter out of range");

endmodule
